// ===== hw/rtl/bgf_pkg.sv =====
// ----------------------------------------------------------------------------
// bgf_pkg
// Shared constants and codes for the graph bridge finder.
// ----------------------------------------------------------------------------
`default_nettype none

package bgf_pkg;

    // Default capacities
    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;

    // Fixed field widths on the ports
    localparam int CFG_W    = 7;
    localparam int NODE_W   = 7;
    localparam int TOTAL_W  = 6;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Node count register reset value
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

    // Input transaction kinds
    typedef enum logic [0:0] {
        OP_ADD    = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgf_ram.sv =====
// ----------------------------------------------------------------------------
// bgf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/graph_bridge_finder.sv =====
// Edge load: one transaction per cycle while idle; the input stays ready after each add.
// Finish: depth-first search that scans every stored edge for each visited node
// and then pops its frame, followed by an emission sweep over node pairs (lo, hi)
// with lo < hi that ends when the last bridge is sent.
// Reset (aresetn low, synchronous) empties the graph and sets node_count to 64;
// after each finish the graph is emptied again and node_count is kept.
// ----------------------------------------------------------------------------
// graph_bridge_finder
// Loads undirected edges, finds the bridges by depth-first search and sends
// them out sorted by endpoint pair.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bridge_finder #(
    parameter int MAX_NODES = bgf_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = bgf_pkg::MAX_EDGES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration: node_count
    input  wire logic                          cfg_wr_en,
    input  wire logic [bgf_pkg::CFG_W-1:0]     cfg_wr_data,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bgf_pkg::S_DATA_W-1:0]  s_tdata,  // node_a[6:0], node_b[13:7]
    input  wire logic [0:0]                    s_tuser,  // operation[0]
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [bgf_pkg::M_DATA_W-1:0]  m_tdata,  // bridge_low[6:0],
                                                         // bridge_high[13:7],
                                                         // bridge_total[19:14],
                                                         // edges_dropped[20]
    output logic      [0:0]                    m_tuser,  // none_found[0]
    output logic                               m_tlast
);

    import bgf_pkg::*;

    localparam int NW   = $clog2(MAX_NODES);
    localparam int NCW  = NW + 1;
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int CMPW = (NCW > NODE_W) ? NCW : NODE_W;

    // Search frame held on the stack
    typedef struct packed {
        logic [NW-1:0]  node;
        logic [NW-1:0]  parent;
        logic           has_parent;
        logic [ECW-1:0] next_edge;
        logic [NW-1:0]  entry;
        logic [NW-1:0]  low;
        logic [NW-1:0]  parent_entry;
    } frame_t;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ROOT  = 11'b000_0000_0010,
        S_SCAN  = 11'b000_0000_0100,
        S_EVAL  = 11'b000_0000_1000,
        S_BACK  = 11'b000_0001_0000,
        S_POPW  = 11'b000_0010_0000,
        S_ELO   = 11'b000_0100_0000,
        S_ELOW  = 11'b000_1000_0000,
        S_ERD   = 11'b001_0000_0000,
        S_ECHK  = 11'b010_0000_0000,
        S_ENONE = 11'b100_0000_0000
    } state_t;

    // Control registers
    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       nc_reg;
    logic [ECW-1:0]         eload_reg, eload_next;
    logic                   drop_reg, drop_next;
    logic [MAX_NODES-1:0]   visited_reg, visited_next;
    logic [MAX_NODES-1:0]   brg_reg, brg_next;
    logic [NCW-1:0]         clk_reg, clk_next;
    logic [NCW-1:0]         root_reg, root_next;
    logic [NW-1:0]          sp_reg, sp_next;
    logic                   dout_reg, dout_next;
    logic [NW-1:0]          bcnt_reg, bcnt_next;
    logic [NW-1:0]          ecnt_reg, ecnt_next;
    logic                   mv_reg, mv_next;

    // Payload registers
    frame_t                 cur_reg, cur_next;
    logic [NW-1:0]          lo_reg, lo_next;
    logic [NW-1:0]          hi_reg, hi_next;
    logic [NW-1:0]          plo_reg, plo_next;
    logic                   blo_reg, blo_next;
    logic [NODE_W-1:0]      mlow_reg, mlow_next;
    logic [NODE_W-1:0]      mhigh_reg, mhigh_next;
    logic [TOTAL_W-1:0]     mtot_reg, mtot_next;
    logic                   mnone_reg, mnone_next;
    logic                   mdrop_reg, mdrop_next;
    logic                   mlast_reg, mlast_next;

    // Memory ports
    logic                   edge_we;
    logic [EAW-1:0]         edge_waddr, edge_raddr;
    logic [2*NW-1:0]        edge_wdata, edge_rdata;
    logic                   ent_we;
    logic [NW-1:0]          ent_waddr, ent_raddr, ent_wdata, ent_rdata;
    logic                   stk_we;
    logic [NW-1:0]          stk_waddr, stk_raddr;
    frame_t                 stk_wdata, stk_rdata;
    logic                   par_we;
    logic [NW-1:0]          par_waddr, par_raddr, par_wdata, par_rdata;

    // Combinational helpers
    logic [NCW-1:0]         n_eff;
    logic [NODE_W-1:0]      in_a, in_b;
    logic                   add_ok;
    logic                   out_free;
    logic [NW-1:0]          ed_x, ed_y, to_node;
    logic                   ed_oor, ed_hit, hit;
    logic                   is_last;

    bgf_ram #(.WIDTH(2*NW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    bgf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_entry_ram (
        .aclk(aclk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    bgf_ram #(.WIDTH($bits(frame_t)), .DEPTH(MAX_NODES)) u_stack_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    bgf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent_ram (
        .aclk(aclk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    // Effective node count
    always_comb begin
        if (nc_reg == '0) begin
            n_eff = NCW'(1);
        end else if (int'(nc_reg) > MAX_NODES) begin
            n_eff = NCW'(MAX_NODES);
        end else begin
            n_eff = NCW'(nc_reg);
        end
    end

    assign in_a     = s_tdata[NODE_W-1:0];
    assign in_b     = s_tdata[2*NODE_W-1:NODE_W];
    assign add_ok   = (in_a != '0) && (CMPW'(in_a) <= CMPW'(n_eff)) &&
                      (in_b != '0) && (CMPW'(in_b) <= CMPW'(n_eff)) &&
                      (int'(eload_reg) < MAX_EDGES);
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Decode the edge word read for the current frame
    assign ed_x   = edge_rdata[NW-1:0];
    assign ed_y   = edge_rdata[2*NW-1:NW];
    assign ed_oor = ({1'b0, ed_x} >= n_eff) || ({1'b0, ed_y} >= n_eff);
    always_comb begin
        ed_hit  = 1'b1;
        to_node = ed_y;
        if (ed_x == cur_reg.node) begin
            to_node = ed_y;
        end else if (ed_y == cur_reg.node) begin
            to_node = ed_x;
        end else begin
            ed_hit = 1'b0;
        end
    end

    // Pair (lo, hi) is a bridge if either end hangs from the other by a bridge
    assign hit     = (brg_reg[hi_reg] && (par_rdata == lo_reg)) ||
                     (blo_reg && (plo_reg == hi_reg));
    assign is_last = ((ecnt_reg + NW'(1)) == bcnt_reg);

    // Next-state logic
    always_comb begin
        state_next   = state_reg;
        eload_next   = eload_reg;
        drop_next    = drop_reg;
        visited_next = visited_reg;
        brg_next     = brg_reg;
        clk_next     = clk_reg;
        root_next    = root_reg;
        sp_next      = sp_reg;
        dout_next    = dout_reg;
        bcnt_next    = bcnt_reg;
        ecnt_next    = ecnt_reg;
        cur_next     = cur_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        plo_next     = plo_reg;
        blo_next     = blo_reg;
        mlow_next    = mlow_reg;
        mhigh_next   = mhigh_reg;
        mtot_next    = mtot_reg;
        mnone_next   = mnone_reg;
        mdrop_next   = mdrop_reg;
        mlast_next   = mlast_reg;
        mv_next      = mv_reg && !m_tready;

        edge_we    = 1'b0;
        edge_waddr = eload_reg[EAW-1:0];
        edge_wdata = {NW'(in_b - NODE_W'(1)), NW'(in_a - NODE_W'(1))};
        edge_raddr = cur_reg.next_edge[EAW-1:0];
        ent_we     = 1'b0;
        ent_waddr  = to_node;
        ent_wdata  = NW'(clk_reg);
        ent_raddr  = to_node;
        stk_we     = 1'b0;
        stk_waddr  = sp_reg;
        stk_wdata  = cur_reg;
        stk_raddr  = sp_reg - NW'(1);
        par_we     = 1'b0;
        par_waddr  = cur_reg.node;
        par_wdata  = cur_reg.parent;
        par_raddr  = hi_reg;

        unique case (state_reg)
            S_IDLE: begin
                // Take an edge, drop an invalid one, or start the search
                if (s_tvalid) begin
                    if (op_t'(s_tuser[0]) == OP_FINISH) begin
                        dout_next  = drop_reg;
                        clk_next   = '0;
                        root_next  = '0;
                        sp_next    = '0;
                        bcnt_next  = '0;
                        ecnt_next  = '0;
                        state_next = S_ROOT;
                    end else if (add_ok) begin
                        edge_we    = 1'b1;
                        eload_next = eload_reg + ECW'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                end
            end

            S_ROOT: begin
                // Find the next unvisited root in ascending order, or start the sweep
                if (root_reg == n_eff) begin
                    lo_next    = '0;
                    state_next = (bcnt_reg == '0) ? S_ENONE : S_ELO;
                end else begin
                    root_next = root_reg + NCW'(1);
                    if (!visited_reg[root_reg[NW-1:0]]) begin
                        cur_next.node         = root_reg[NW-1:0];
                        cur_next.parent       = '0;
                        cur_next.has_parent   = 1'b0;
                        cur_next.next_edge    = '0;
                        cur_next.entry        = NW'(clk_reg);
                        cur_next.low          = NW'(clk_reg);
                        cur_next.parent_entry = '0;
                        ent_we    = 1'b1;
                        ent_waddr = root_reg[NW-1:0];
                        visited_next[root_reg[NW-1:0]] = 1'b1;
                        clk_next   = clk_reg + NCW'(1);
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Fetch the next edge, or pop the frame when all are seen; a root frame ends its tree
                if (cur_reg.next_edge < eload_reg) begin
                    cur_next.next_edge = cur_reg.next_edge + ECW'(1);
                    state_next = S_EVAL;
                end else if (cur_reg.has_parent) begin
                    par_we = 1'b1;
                    if (cur_reg.low > cur_reg.parent_entry) begin
                        brg_next[cur_reg.node] = 1'b1;
                        bcnt_next = bcnt_reg + NW'(1);
                    end
                    sp_next    = sp_reg - NW'(1);
                    state_next = S_POPW;
                end else begin
                    state_next = S_ROOT;
                end
            end

            S_EVAL: begin
                // Skip, look up a back edge, or descend
                state_next = S_SCAN;
                if (ed_oor) begin
                    dout_next = 1'b1;
                end else if (ed_hit &&
                             !(cur_reg.has_parent && to_node == cur_reg.parent)) begin
                    if (visited_reg[to_node]) begin
                        state_next = S_BACK;
                    end else begin
                        stk_we = 1'b1;
                        ent_we = 1'b1;
                        visited_next[to_node] = 1'b1;
                        cur_next.node         = to_node;
                        cur_next.parent       = cur_reg.node;
                        cur_next.has_parent   = 1'b1;
                        cur_next.next_edge    = '0;
                        cur_next.entry        = NW'(clk_reg);
                        cur_next.low          = NW'(clk_reg);
                        cur_next.parent_entry = cur_reg.entry;
                        clk_next = clk_reg + NCW'(1);
                        sp_next  = sp_reg + NW'(1);
                    end
                end
            end

            S_BACK: begin
                // Lower the link through a back edge
                if (ent_rdata < cur_reg.low) begin
                    cur_next.low = ent_rdata;
                end
                state_next = S_SCAN;
            end

            S_POPW: begin
                // Restore the parent frame and fold in the child's link
                cur_next = stk_rdata;
                if (cur_reg.low < stk_rdata.low) begin
                    cur_next.low = cur_reg.low;
                end
                state_next = S_SCAN;
            end

            S_ELO: begin
                // Fetch the parent of the lower endpoint
                par_raddr  = lo_reg;
                hi_next    = lo_reg + NW'(1);
                state_next = S_ELOW;
            end

            S_ELOW: begin
                plo_next   = par_rdata;
                blo_next   = brg_reg[lo_reg];
                state_next = S_ERD;
            end

            S_ERD: begin
                state_next = S_ECHK;
            end

            S_ECHK: begin
                // Send the pair if it is a bridge, then advance the sweep
                if (!hit || out_free) begin
                    if (hit) begin
                        mv_next    = 1'b1;
                        mlow_next  = NODE_W'({1'b0, lo_reg} + NCW'(1));
                        mhigh_next = NODE_W'({1'b0, hi_reg} + NCW'(1));
                        mtot_next  = TOTAL_W'(bcnt_reg);
                        mnone_next = 1'b0;
                        mdrop_next = dout_reg;
                        mlast_next = is_last;
                        ecnt_next  = ecnt_reg + NW'(1);
                    end
                    if (hit && is_last) begin
                        eload_next   = '0;
                        drop_next    = 1'b0;
                        visited_next = '0;
                        brg_next     = '0;
                        state_next   = S_IDLE;
                    end else if ({1'b0, hi_reg} == n_eff - NCW'(1)) begin
                        lo_next    = lo_reg + NW'(1);
                        state_next = S_ELO;
                    end else begin
                        hi_next    = hi_reg + NW'(1);
                        state_next = S_ERD;
                    end
                end
            end

            S_ENONE: begin
                // Report that no bridge exists
                if (out_free) begin
                    mv_next      = 1'b1;
                    mlow_next    = '0;
                    mhigh_next   = '0;
                    mtot_next    = '0;
                    mnone_next   = 1'b1;
                    mdrop_next   = dout_reg;
                    mlast_next   = 1'b1;
                    eload_next   = '0;
                    drop_next    = 1'b0;
                    visited_next = '0;
                    brg_next     = '0;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            nc_reg      <= NODE_COUNT_RST;
            eload_reg   <= '0;
            drop_reg    <= 1'b0;
            visited_reg <= '0;
            brg_reg     <= '0;
            clk_reg     <= '0;
            root_reg    <= '0;
            sp_reg      <= '0;
            dout_reg    <= 1'b0;
            bcnt_reg    <= '0;
            ecnt_reg    <= '0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                nc_reg <= cfg_wr_data;
            end
            eload_reg   <= eload_next;
            drop_reg    <= drop_next;
            visited_reg <= visited_next;
            brg_reg     <= brg_next;
            clk_reg     <= clk_next;
            root_reg    <= root_next;
            sp_reg      <= sp_next;
            dout_reg    <= dout_next;
            bcnt_reg    <= bcnt_next;
            ecnt_reg    <= ecnt_next;
            mv_reg      <= mv_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        plo_reg   <= plo_next;
        blo_reg   <= blo_next;
        mlow_reg  <= mlow_next;
        mhigh_reg <= mhigh_next;
        mtot_reg  <= mtot_next;
        mnone_reg <= mnone_next;
        mdrop_reg <= mdrop_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = M_DATA_W'({mdrop_reg, mtot_reg, mhigh_reg, mlow_reg});
    assign m_tuser  = mnone_reg;
    assign m_tlast  = mlast_reg;

    // Every visit is counted exactly once during a search
    a_visit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> ($countones(visited_reg) == int'(clk_reg)))
        else $error("visit clock out of step with visited marks");

    // The no-bridge result stands alone
    a_none_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata[19:14] == '0))
        else $error("none result not final or has a count");

    // Edge pointer never passes the loaded count
    a_edge_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (cur_reg.next_edge <= eload_reg))
        else $error("edge pointer beyond loaded edges");

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire
